[hdl/tis_pkg.sv]
package tis_pkg;

	localparam int LETTER_W = 5;

	typedef struct packed {
		logic                mode;
		logic [LETTER_W-1:0] letter;
		logic                letter_valid;
		logic                key_end;
	} item_t;

	typedef struct packed {
		logic found;
		logic status;
	} result_t;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic walk;
		logic mark_rd;
		logic emit;
	} tis_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_done;
		logic key_end;
		logic out_free;
	} tis_sts_t;

endpackage

[hdl/trie_insert_search.sv]
// channel   dir  payload   handshake
// item      in   item_t    item_valid / item_stall
// result    out  result_t  result_valid / result_stall
//
// a letter item is a child table read, then walk and optional allocate
// a key-end item adds the end mark read and the emit, plus any wait on result_stall
// after reset a clearing pass over every child table entry
// zeroes the child table and end marks; item_stall stays high until it is done
// a waiting result does not block the next request unless another result is due
module trie_insert_search
	import tis_pkg::*;
#(
	parameter int NODES    = 256,
	parameter int ALPHABET = 26
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	tis_cmd_t cmd;
	tis_sts_t sts;

	tis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	tis_dp #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

[hdl/tis_ctrl.sv]
module tis_ctrl
	import tis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  tis_sts_t sts,
	output tis_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_MARK  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				state_d  = sts.key_end ? ST_MARK : ST_IDLE;
			end
			ST_MARK: begin
				// end mark of the node the walk stopped on
				cmd.mark_rd = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

[hdl/tis_dp.sv]
module tis_dp
	import tis_pkg::*;
#(
	parameter int NODES    = 256,
	parameter int ALPHABET = 26
) (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result,
	input  tis_cmd_t cmd,
	output tis_sts_t sts
);

	localparam int PW         = $clog2(NODES);
	localparam int LW         = $clog2(ALPHABET);
	localparam int AW         = PW + LW;
	localparam int MEM_DEPTH  = 1 << AW;
	localparam int MARK_DEPTH = 1 << PW;

	logic [PW-1:0] child_mem [MEM_DEPTH];
	logic          marks [MARK_DEPTH];

	item_t         item_q;
	logic [PW-1:0] child_rd_q;
	logic          mark_rd_q;
	logic [PW-1:0] cur_q;
	logic [PW:0]   used_q;
	logic          missed_q;
	logic          ovf_q;
	logic [AW-1:0] sweep_q;
	result_t       out_q;
	logic          out_valid_q;

	logic          stopped;
	logic          letter_ok;
	logic          pool_free;
	logic          alloc;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [PW-1:0] wr_data;

	assign stopped   = missed_q || ovf_q;
	assign letter_ok = item_q.letter_valid && (32'(item_q.letter) < ALPHABET);
	assign pool_free = used_q < (PW+1)'(NODES);
	assign alloc     = cmd.walk && letter_ok && !stopped && (child_rd_q == '0)
		&& (item_q.mode == MODE_INSERT) && pool_free;

	always_comb begin
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = '0;
		end else begin
			wr_en   = alloc;
			wr_addr = {cur_q, LW'(item_q.letter)};
			wr_data = used_q[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			child_mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			child_rd_q <= child_mem[{cur_q, LW'(item.letter)}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (sweep_q[LW-1:0] == '0) begin
				marks[sweep_q[AW-1:LW]] <= 1'b0;
			end
		end else if (cmd.emit && !stopped && item_q.mode == MODE_INSERT) begin
			marks[cur_q] <= 1'b1;
		end
		if (cmd.mark_rd) begin
			mark_rd_q <= marks[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.emit) begin
			out_q.found  <= (item_q.mode == MODE_SEARCH) && !stopped && mark_rd_q;
			out_q.status <= ovf_q ? STATUS_FULL : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			cur_q       <= '0;
			used_q      <= (PW+1)'(1);
			missed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.walk && letter_ok && !stopped) begin
				if (child_rd_q != '0) begin
					cur_q <= child_rd_q;
				end else if (item_q.mode == MODE_SEARCH) begin
					missed_q <= 1'b1;
				end else if (pool_free) begin
					cur_q  <= used_q[PW-1:0];
					used_q <= used_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				cur_q    <= '0;
				missed_q <= 1'b0;
				ovf_q    <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.sweep_done = cmd.clear && (sweep_q == '1);
	assign sts.key_end    = item_q.key_end;
	assign sts.out_free   = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[hdl/tis_chk.sv]
module tis_chk
	import tis_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("request taken while busy");

	// only a key end produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !item.key_end |=> !$rose(result_valid))
		else $error("result without key end");

	// a full pool never reports a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.found && result.status == STATUS_FULL))
		else $error("found with full status");

endmodule

bind trie_insert_search tis_chk u_tis_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[tb/trie_insert_search_test.sv]
module trie_insert_search_test;
	import tis_pkg::*;

	localparam int TRIE_NODES  = 256;
	localparam int LETTERS     = 26;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [3:0]      len;
		logic [7:0][4:0] ch;
	} word_t;

	class trie_scoreboard;
		bit [15:0] links [TRIE_NODES*LETTERS];
		bit        marked [TRIE_NODES];
		int        alloc_count;
		int        walk_at;
		bit        missed;
		bit        full;
		result_t   expected_q [$];
		int        errors;
		int        inserts;
		int        searches;
		int        hits;
		int        full_keys;

		function new();
			alloc_count = 1;
			walk_at     = 0;
			missed      = 1'b0;
			full        = 1'b0;
			errors      = 0;
			inserts     = 0;
			searches    = 0;
			hits        = 0;
			full_keys   = 0;
		endfunction

		function void note_request(item_t it);
			int      slot;
			result_t exp_r;
			// a stopped walk ignores the rest of the key
			if (it.letter_valid && it.letter < LETTERS && !missed && !full) begin
				slot = walk_at * LETTERS + int'(it.letter);
				if (links[slot] != 0) begin
					walk_at = int'(links[slot]);
				end else if (it.mode == MODE_SEARCH) begin
					missed = 1'b1;
				end else if (alloc_count < TRIE_NODES) begin
					links[slot] = 16'(alloc_count);
					walk_at     = alloc_count;
					alloc_count++;
				end else begin
					full = 1'b1;
				end
			end
			if (!it.key_end)
				return;
			exp_r.found = 1'b0;
			if (!missed && !full) begin
				if (it.mode == MODE_SEARCH)
					exp_r.found = marked[walk_at];
				else
					marked[walk_at] = 1'b1;
			end
			exp_r.status = full ? STATUS_FULL : STATUS_OK;
			if (it.mode == MODE_SEARCH) begin
				searches++;
				if (exp_r.found)
					hits++;
			end else begin
				inserts++;
			end
			if (full)
				full_keys++;
			expected_q.push_back(exp_r);
			walk_at = 0;
			missed  = 1'b0;
			full    = 1'b0;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: found %0b status %0b", got.found, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0b, actual %0b", want.found, got.found);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0b, actual %0b", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	trie_scoreboard sb;
	word_t          known [$];
	int             items_sent;
	int             requests_taken;
	int             cycles;

	trie_insert_search uut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("trie_insert_search_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sb.note_request(item);
				requests_taken++;
			end
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// mostly short gaps, a few long ones, none inside the calm window
	function automatic int idle_cycles();
		int r;
		if (requests_taken >= 120 && requests_taken < 180)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t mk(logic m, int l, logic lv, logic ke);
		item_t r;
		r.mode         = m;
		r.letter       = l[4:0];
		r.letter_valid = lv;
		r.key_end      = ke;
		return r;
	endfunction

	function automatic word_t random_word(int minlen, int maxlen, int top);
		word_t w;
		w.len = 4'($urandom_range(minlen, maxlen));
		for (int i = 0; i < 8; i++)
			w.ch[i] = 5'($urandom_range(0, top));
		return w;
	endfunction

	// receiver: random stalls plus one long hold-off once traffic is going
	initial begin
		int  stall_left;
		int  hold_left;
		bit  hold_done;
		result_stall = 1'b0;
		stall_left   = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && requests_taken >= 260) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_left = idle_cycles();
				result_stall <= (stall_left > 0) && ($urandom_range(0, 2) == 0);
			end
		end
	end

	task automatic send_item(item_t it);
		int gap;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		if (it.key_end || (it.letter_valid && it.letter < LETTERS))
			items_sent++;
		gap = idle_cycles();
		if (gap > 0) begin
			item_valid <= 1'b0;
			item       <= item_t'(8'($urandom_range(0, 255)));
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_word(logic m, word_t w);
		if (w.len == 0)
			send_item(mk(m, 0, 1'b0, 1'b1));
		for (int i = 0; i < w.len; i++)
			send_item(mk(m, int'(w.ch[i]), 1'b1, i == w.len - 1));
	endtask

	// broken keys: mixed modes, letters out of range, letterless items
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++)
			send_item(mk(1'($urandom_range(0, 1)), $urandom_range(0, 31),
				$urandom_range(0, 3) != 0, i == n - 1));
	endtask

	initial begin
		word_t w;
		int    pick;
		bit    paused;
		sb             = new();
		items_sent     = 0;
		requests_taken = 0;
		cycles         = 0;
		paused         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		arst_n         = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty key before and after marking the root
		send_item(mk(MODE_SEARCH, 0, 1'b0, 1'b1));
		send_item(mk(MODE_INSERT, 0, 1'b0, 1'b1));
		send_item(mk(MODE_SEARCH, 0, 1'b0, 1'b1));
		send_item(mk(MODE_INSERT, 0, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 25, 1'b1, 1'b1));
		send_item(mk(MODE_SEARCH, 0, 1'b1, 1'b0));
		send_item(mk(MODE_SEARCH, 25, 1'b1, 1'b1));
		// unmarked prefix
		send_item(mk(MODE_SEARCH, 0, 1'b1, 1'b1));
		// miss, then a letter that must be ignored
		send_item(mk(MODE_SEARCH, 1, 1'b1, 1'b0));
		send_item(mk(MODE_SEARCH, 2, 1'b1, 1'b1));
		// letterless item inside a key
		send_item(mk(MODE_INSERT, 0, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 31, 1'b0, 1'b0));
		send_item(mk(MODE_INSERT, 1, 1'b1, 1'b1));
		// letters past z count as no letter
		send_item(mk(MODE_INSERT, 2, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 31, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 26, 1'b1, 1'b1));
		send_item(mk(MODE_SEARCH, 2, 1'b1, 1'b1));
		// mode flips within a key
		send_item(mk(MODE_INSERT, 3, 1'b1, 1'b0));
		send_item(mk(MODE_SEARCH, 4, 1'b1, 1'b1));
		send_item(mk(MODE_SEARCH, 0, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 24, 1'b1, 1'b1));
		send_item(mk(MODE_SEARCH, 0, 1'b1, 1'b0));
		send_item(mk(MODE_SEARCH, 24, 1'b1, 1'b1));
		send_item(mk(MODE_SEARCH, 16, 1'b1, 1'b0));
		send_item(mk(MODE_INSERT, 17, 1'b1, 1'b1));

		while (items_sent < 650) begin
			if (!paused && items_sent >= 500) begin
				paused = 1'b1;
				item_valid <= 1'b0;
				while (sb.expected_q.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (items_sent >= 400 && sb.alloc_count < TRIE_NODES && pick < 50) begin
				// long fresh words to run the pool dry
				w = random_word(8, 8, 25);
				send_word(MODE_INSERT, w);
				known.push_back(w);
			end else if (pick < 40) begin
				w = random_word(($urandom_range(0, 19) == 0) ? 0 : 1, 6,
					$urandom_range(0, 1) ? 3 : 25);
				send_word(MODE_INSERT, w);
				known.push_back(w);
			end else if (pick < 65 && known.size() > 0) begin
				send_word(MODE_SEARCH, known[$urandom_range(0, known.size() - 1)]);
			end else if (pick < 75 && known.size() > 0) begin
				// shortened or lengthened copy of a stored word
				w = known[$urandom_range(0, known.size() - 1)];
				if (w.len > 1 && $urandom_range(0, 1)) begin
					w.len = 4'($urandom_range(1, w.len - 1));
				end else if (w.len < 8) begin
					w.ch[w.len] = 5'($urandom_range(0, 25));
					w.len = w.len + 4'd1;
				end
				send_word(MODE_SEARCH, w);
			end else if (pick < 82) begin
				send_word(MODE_SEARCH, random_word(1, 5, 25));
			end else if (pick < 90 && known.size() > 0) begin
				send_word(MODE_INSERT, known[$urandom_range(0, known.size() - 1)]);
			end else begin
				send_noise();
			end
		end
		item_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("trie_insert_search_test: %0d requests taken, %0d inserts, %0d searches (%0d hits)",
			requests_taken, sb.inserts, sb.searches, sb.hits);
		$display("trie_insert_search_test: %0d keys ran into a full pool, %0d of %0d nodes in use",
			sb.full_keys, sb.alloc_count, TRIE_NODES);
		if (sb.errors == 0)
			$display("trie_insert_search_test: done, clean");
		else
			$display("trie_insert_search_test: done, errors");
		$finish;
	end

endmodule

[sim.f]
hdl/tis_pkg.sv
hdl/tis_ctrl.sv
hdl/tis_dp.sv
hdl/trie_insert_search.sv
hdl/tis_chk.sv
tb/trie_insert_search_test.sv
